[rtl/pmi_pkg.sv]
// Shared constants, codes and controller/datapath interface types for the page map insert block.
package pmi_pkg;

  localparam int TABLE_FRAMES      = 64;
  localparam int ENTRIES_PER_TABLE = 512;
  localparam int IDX_W             = 9;
  localparam int TBL_W             = 6;
  localparam int ADDR_W            = TBL_W + IDX_W;
  localparam int FRAME_W           = 40;
  localparam int ENTRY_W           = FRAME_W + 2;
  localparam int VPAGE_W           = 36;
  localparam int CNT_W             = 7;
  localparam int CFG_IDX_W         = 2;

  localparam logic [1:0] STATUS_MAPPED   = 2'd0;
  localparam logic [1:0] STATUS_NO_TABLE = 2'd1;
  localparam logic [1:0] STATUS_OUTSIDE  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROOT_TABLE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_FREE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_BASE  = 2'd2;

  typedef enum logic [2:0] {
    ST_RST_CLR,
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_CLEAR,
    ST_LINK,
    ST_LEAF,
    ST_DONE
  } pmi_state_t;

  typedef struct packed {
    logic load_item;
    logic eval;
    logic clr_all_wr;
    logic clr_tbl_wr;
    logic link_wr;
    logic leaf_wr;
    logic out_load;
  } pmi_cmd_t;

  typedef struct packed {
    logic present;
    logic rel_oob;
    logic alloc_empty;
    logic level_last;
    logic failed;
    logic cnt_tbl_last;
    logic cnt_all_last;
  } pmi_stat_t;

endpackage

[rtl/pmi_ctrl.sv]
// Controller state machine that sequences the table walk, table clearing and result handoff.
module pmi_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  input  pmi_pkg::pmi_stat_t stat,
  output pmi_pkg::pmi_cmd_t  cmd,
  output pmi_pkg::pmi_state_t state
);

  pmi_pkg::pmi_state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pmi_pkg::ST_RST_CLR: if (stat.cnt_all_last) state_nxt = pmi_pkg::ST_IDLE;
      pmi_pkg::ST_IDLE:    if (in_tvalid) state_nxt = pmi_pkg::ST_READ;
      pmi_pkg::ST_READ: begin
        if (stat.failed) begin
          state_nxt = pmi_pkg::ST_DONE;
        end else if (stat.level_last) begin
          state_nxt = pmi_pkg::ST_LEAF;
        end else begin
          state_nxt = pmi_pkg::ST_EVAL;
        end
      end
      pmi_pkg::ST_EVAL: begin
        if (stat.present) begin
          state_nxt = stat.rel_oob ? pmi_pkg::ST_DONE : pmi_pkg::ST_READ;
        end else begin
          state_nxt = stat.alloc_empty ? pmi_pkg::ST_DONE : pmi_pkg::ST_CLEAR;
        end
      end
      pmi_pkg::ST_CLEAR:   if (stat.cnt_tbl_last) state_nxt = pmi_pkg::ST_LINK;
      pmi_pkg::ST_LINK:    state_nxt = pmi_pkg::ST_READ;
      pmi_pkg::ST_LEAF:    state_nxt = pmi_pkg::ST_DONE;
      pmi_pkg::ST_DONE:    if (!out_valid_r || out_tready) state_nxt = pmi_pkg::ST_IDLE;
      default:             state_nxt = pmi_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_tready = 1'b0;
    case (state_r)
      pmi_pkg::ST_RST_CLR: cmd.clr_all_wr = 1'b1;
      pmi_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load_item = in_tvalid;
      end
      pmi_pkg::ST_EVAL:  cmd.eval = 1'b1;
      pmi_pkg::ST_CLEAR: cmd.clr_tbl_wr = 1'b1;
      pmi_pkg::ST_LINK:  cmd.link_wr = 1'b1;
      pmi_pkg::ST_LEAF:  cmd.leaf_wr = 1'b1;
      pmi_pkg::ST_DONE:  cmd.out_load = !out_valid_r || out_tready;
      default:           cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
    if (cmd.out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pmi_pkg::ST_RST_CLR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign state      = state_r;

endmodule

[rtl/pmi_datapath.sv]
// Datapath with the table store, walk registers, allocator, configuration and result register.
module pmi_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [pmi_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pmi_pkg::FRAME_W-1:0]       cfg_wdata,
  input  logic [79:0]                       in_tdata,
  output logic [23:0]                       out_tdata,
  input  pmi_pkg::pmi_cmd_t                 cmd,
  output pmi_pkg::pmi_stat_t                stat
);

  localparam int AW = pmi_pkg::ADDR_W;
  localparam int IW = pmi_pkg::IDX_W;
  localparam int TW = pmi_pkg::TBL_W;
  localparam int FW = pmi_pkg::FRAME_W;
  localparam int EW = pmi_pkg::ENTRY_W;
  localparam int NW = pmi_pkg::CNT_W;

  logic [EW-1:0] mem [1 << AW];
  logic [EW-1:0] rd_data_r;

  logic [TW-1:0] root_r;
  logic [FW-1:0] base_r;
  logic [NW-1:0] next_free_r, next_free_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;

  logic [pmi_pkg::VPAGE_W-1:0] vpage_r;
  logic [FW-1:0]               frame_r;
  logic [TW-1:0]               table_r, table_nxt;
  logic [TW-1:0]               fresh_r, fresh_nxt;
  logic [1:0]                  level_r, level_nxt;
  logic [1:0]                  status_r, status_nxt;
  logic [1:0]                  added_r, added_nxt;
  logic [AW-1:0]               link_addr_r, link_addr_nxt;
  logic [23:0]                 out_r;

  logic [IW-1:0] idx;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [EW-1:0] wr_data;
  logic          wr_en;
  logic [FW-1:0] rel;
  logic          root_oob;
  logic [NW-1:0] free_left;

  always_comb begin
    case (level_r)
      2'd0:    idx = vpage_r[4*IW-1:3*IW];
      2'd1:    idx = vpage_r[3*IW-1:2*IW];
      2'd2:    idx = vpage_r[2*IW-1:IW];
      default: idx = vpage_r[IW-1:0];
    endcase
  end

  assign rd_addr  = {table_r, idx};
  assign rel      = rd_data_r[EW-1:2] - base_r;
  assign root_oob = {1'b0, root_r} >= NW'(pmi_pkg::TABLE_FRAMES);

  assign stat.present      = rd_data_r[0];
  assign stat.rel_oob      = rel >= FW'(pmi_pkg::TABLE_FRAMES);
  assign stat.alloc_empty  = next_free_r >= NW'(pmi_pkg::TABLE_FRAMES);
  assign stat.level_last   = level_r == 2'd3;
  assign stat.failed       = status_r != pmi_pkg::STATUS_MAPPED;
  assign stat.cnt_tbl_last = &cnt_r[IW-1:0];
  assign stat.cnt_all_last = &cnt_r;

  assign free_left = stat.alloc_empty ? '0 : NW'(pmi_pkg::TABLE_FRAMES) - next_free_r;

  always_comb begin
    wr_en   = cmd.clr_all_wr | cmd.clr_tbl_wr | cmd.link_wr | cmd.leaf_wr;
    wr_addr = cnt_r;
    wr_data = '0;
    if (cmd.clr_tbl_wr) begin
      wr_addr = {fresh_r, cnt_r[IW-1:0]};
    end else if (cmd.link_wr) begin
      wr_addr = link_addr_r;
      wr_data = {base_r + FW'(fresh_r), 2'b11};
    end else if (cmd.leaf_wr) begin
      wr_addr = {table_r, vpage_r[IW-1:0]};
      wr_data = {frame_r, 2'b11};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    next_free_nxt = next_free_r;
    cnt_nxt       = cnt_r;
    table_nxt     = table_r;
    fresh_nxt     = fresh_r;
    level_nxt     = level_r;
    status_nxt    = status_r;
    added_nxt     = added_r;
    link_addr_nxt = link_addr_r;
    if (cmd.clr_all_wr || cmd.clr_tbl_wr) cnt_nxt = cnt_r + 1'b1;
    if (cmd.load_item) begin
      table_nxt  = root_r;
      level_nxt  = 2'd0;
      added_nxt  = 2'd0;
      status_nxt = root_oob ? pmi_pkg::STATUS_OUTSIDE : pmi_pkg::STATUS_MAPPED;
    end
    if (cmd.eval) begin
      if (stat.present) begin
        if (stat.rel_oob) begin
          status_nxt = pmi_pkg::STATUS_OUTSIDE;
        end else begin
          table_nxt = rel[TW-1:0];
          level_nxt = level_r + 1'b1;
        end
      end else if (stat.alloc_empty) begin
        status_nxt = pmi_pkg::STATUS_NO_TABLE;
      end else begin
        fresh_nxt     = next_free_r[TW-1:0];
        next_free_nxt = next_free_r + 1'b1;
        link_addr_nxt = rd_addr;
        cnt_nxt       = '0;
      end
    end
    if (cmd.link_wr) begin
      added_nxt = added_r + 1'b1;
      table_nxt = fresh_r;
      level_nxt = level_r + 1'b1;
    end
    if (cfg_we && cfg_index == pmi_pkg::CFG_FIRST_FREE) next_free_nxt = cfg_wdata[NW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r       <= '0;
      base_r       <= '0;
      next_free_r  <= NW'(1);
      cnt_r        <= '0;
    end else begin
      next_free_r <= next_free_nxt;
      cnt_r       <= cnt_nxt;
      if (cfg_we) begin
        case (cfg_index)
          pmi_pkg::CFG_ROOT_TABLE: root_r       <= cfg_wdata[TW-1:0];
          pmi_pkg::CFG_TABLE_BASE: base_r       <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    table_r     <= table_nxt;
    fresh_r     <= fresh_nxt;
    level_r     <= level_nxt;
    status_r    <= status_nxt;
    added_r     <= added_nxt;
    link_addr_r <= link_addr_nxt;
    if (cmd.load_item) begin
      vpage_r <= in_tdata[pmi_pkg::VPAGE_W-1:0];
      frame_r <= in_tdata[pmi_pkg::VPAGE_W+FW-1:pmi_pkg::VPAGE_W];
    end
    if (cmd.out_load) begin
      out_r <= {7'd0, free_left,
                stat.failed ? TW'(0) : table_r,
                added_r, status_r};
    end
  end

  assign out_tdata = out_r;

endmodule

[rtl/four_level_page_map_insert.sv]
// Top level of the four-level page map insert block: controller, datapath and assertions.
// After reset the whole table store is cleared, one entry at a time, before the first word is accepted.
// A successful mapping with no new table goes READ and EVAL at three levels, then READ, LEAF and DONE.
// Each new table adds a CLEAR of all its 512 entries, one entry at a time, and a LINK write.
// One mapping is in work at a time, so a new word is accepted only once the last result is loaded.
// Configuration registers and the allocator reset synchronously with rst_n low.
module four_level_page_map_insert (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [pmi_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pmi_pkg::FRAME_W-1:0]   cfg_wdata,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // Fields from bit 0: virtual_page[35:0], physical_frame[75:36], zero fill.
  input  logic [79:0]                   in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // Fields from bit 0: status[1:0], tables_added[3:2], leaf_table[9:4],
  // free_tables_left[16:10], zero fill.
  output logic [23:0]                   out_tdata
);

  pmi_pkg::pmi_cmd_t   cmd;
  pmi_pkg::pmi_stat_t  stat;
  pmi_pkg::pmi_state_t state;

  pmi_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd),
    .state      (state)
  );

  pmi_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tdata  (in_tdata),
    .out_tdata (out_tdata),
    .cmd       (cmd),
    .stat      (stat)
  );

  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("A second word was offered acceptance during a walk.");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[1:0] != 2'd3)
    else $error("Result carries an undefined status code.");

  a_error_leaf: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] != pmi_pkg::STATUS_MAPPED |-> out_tdata[9:4] == '0)
    else $error("Failed mapping reports a leaf table.");

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    state == pmi_pkg::ST_IDLE |-> !(cmd.clr_all_wr || cmd.clr_tbl_wr ||
                                    cmd.link_wr || cmd.leaf_wr))
    else $error("Table store written while idle.");

endmodule

[verif/four_level_page_map_insert_tb.sv]
// Self-checking testbench for four_level_page_map_insert: directed and random mappings.
module four_level_page_map_insert_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CFG_IDX_W         = pmi_pkg::CFG_IDX_W;
  localparam int FRAME_W           = pmi_pkg::FRAME_W;
  localparam int VPAGE_W           = pmi_pkg::VPAGE_W;
  localparam int CNT_W             = pmi_pkg::CNT_W;
  localparam int TBL_W             = pmi_pkg::TBL_W;
  localparam int IDX_W             = pmi_pkg::IDX_W;
  localparam int ENTRY_W           = pmi_pkg::ENTRY_W;
  localparam int TABLE_FRAMES      = pmi_pkg::TABLE_FRAMES;
  localparam int ENTRIES_PER_TABLE = pmi_pkg::ENTRIES_PER_TABLE;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam logic [1:0] ENTRY_LINK_BITS = 2'b11;
  localparam int unsigned IDLE_LIMIT = 120000;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned HOLD_AT = 600;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 211;
  localparam int POOL_N = 12;
  localparam int DIR_N = 22;
  localparam logic [FRAME_W-1:0] FRAME_MAX = 40'hFF_FFFF_FFFF;
  localparam logic [VPAGE_W-1:0] VPAGE_MAX = 36'hF_FFFF_FFFF;

  typedef struct packed {
    logic [CNT_W-1:0] free_left;
    logic [TBL_W-1:0] leaf;
    logic [1:0]       added;
    logic [1:0]       status;
  } map_result_t;

  typedef struct packed {
    logic                 is_cfg;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [FRAME_W-1:0]   reg_val;
    logic [VPAGE_W-1:0]   vp;
    logic [FRAME_W-1:0]   fr;
    logic                 typed;
    map_result_t          res;
  } dir_row_t;

  typedef enum int {SINK_OPEN, SINK_COIN, SINK_RARE} sink_mode_t;

  logic                 clk;
  logic                 rst_n      = 1'b0;
  logic                 cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [FRAME_W-1:0]   cfg_wdata  = '0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [79:0]          in_tdata   = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [23:0]          out_tdata;

  four_level_page_map_insert dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  logic [ENTRY_W-1:0] page_store [TABLE_FRAMES*ENTRIES_PER_TABLE];
  logic [TBL_W-1:0]   root_q;
  logic [CNT_W-1:0]   next_free_q;
  logic [FRAME_W-1:0] base_q;

  map_result_t mapping_results_due [$];
  int unsigned mismatches  = 0;
  int unsigned items_taken = 0;
  int unsigned burst_left  = 0;
  int unsigned idle_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic map_result_t insert_mapping(input logic [VPAGE_W-1:0] vp,
                                                 input logic [FRAME_W-1:0] fr);
    map_result_t        res;
    int unsigned        tbl, fresh, slot, added;
    logic [IDX_W-1:0]   idx;
    logic [ENTRY_W-1:0] ent;
    logic [FRAME_W-1:0] rel;
    logic [1:0]         st;
    st    = pmi_pkg::STATUS_MAPPED;
    added = 0;
    tbl   = root_q;
    if (tbl >= TABLE_FRAMES) st = pmi_pkg::STATUS_OUTSIDE;
    for (int lvl = 0; lvl < 3; lvl++) begin
      if (st == pmi_pkg::STATUS_MAPPED) begin
        idx  = IDX_W'(vp >> (IDX_W * (3 - lvl)));
        slot = tbl * ENTRIES_PER_TABLE + idx;
        ent  = page_store[slot];
        if (ent[0]) begin
          rel = ent[ENTRY_W-1:2] - base_q;
          if (rel >= TABLE_FRAMES) st = pmi_pkg::STATUS_OUTSIDE;
          else tbl = rel[TBL_W-1:0];
        end else if (next_free_q >= TABLE_FRAMES) begin
          st = pmi_pkg::STATUS_NO_TABLE;
        end else begin
          fresh       = next_free_q;
          next_free_q = next_free_q + 1'b1;
          for (int e = 0; e < ENTRIES_PER_TABLE; e++)
            page_store[fresh * ENTRIES_PER_TABLE + e] = '0;
          page_store[slot] = {base_q + FRAME_W'(fresh), ENTRY_LINK_BITS};
          added++;
          tbl = fresh;
        end
      end
    end
    if (st == pmi_pkg::STATUS_MAPPED)
      page_store[tbl * ENTRIES_PER_TABLE + vp[IDX_W-1:0]] = {fr, ENTRY_LINK_BITS};
    res.status    = st;
    res.added     = 2'(added);
    res.leaf      = (st == pmi_pkg::STATUS_MAPPED) ? TBL_W'(tbl) : '0;
    res.free_left = (next_free_q >= TABLE_FRAMES) ? '0 : CNT_W'(TABLE_FRAMES - next_free_q);
    return res;
  endfunction

  function automatic dir_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [FRAME_W-1:0] val);
    dir_row_t r;
    r         = '0;
    r.is_cfg  = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  function automatic dir_row_t item_row(input logic [VPAGE_W-1:0] vp,
                                        input logic [FRAME_W-1:0] fr);
    dir_row_t r;
    r    = '0;
    r.vp = vp;
    r.fr = fr;
    return r;
  endfunction

  function automatic dir_row_t known_row(input logic [VPAGE_W-1:0] vp,
                                         input logic [FRAME_W-1:0] fr,
                                         input logic [1:0] st, input int unsigned added,
                                         input int unsigned leaf, input int unsigned free_left);
    dir_row_t r;
    r               = item_row(vp, fr);
    r.typed         = 1'b1;
    r.res.status    = st;
    r.res.added     = 2'(added);
    r.res.leaf      = TBL_W'(leaf);
    r.res.free_left = CNT_W'(free_left);
    return r;
  endfunction

  task automatic check_field(input string what, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
      mismatches++;
    end
  endtask

  task automatic put_item(input logic [VPAGE_W-1:0] vp, input logic [FRAME_W-1:0] fr,
                          input logic typed, input map_result_t typed_res);
    map_result_t res;
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, ($urandom_range(0, 7) == 0) ? 40 : 4)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, fr, vp};
    do @(posedge clk); while (in_tready !== 1'b1);
    res = insert_mapping(vp, fr);
    mapping_results_due.push_back(typed ? typed_res : res);
    burst_left--;
    items_taken++;
  endtask

  task automatic settle;
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (mapping_results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FRAME_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      pmi_pkg::CFG_ROOT_TABLE: root_q = val[TBL_W-1:0];
      pmi_pkg::CFG_FIRST_FREE: next_free_q = val[CNT_W-1:0];
      pmi_pkg::CFG_TABLE_BASE: base_q = val;
      default: ;
    endcase
  endtask

  // The receiver mixes open, coin-flip, rarely-stalled and one long stalled stretch.
  sink_mode_t  sink_mode = SINK_OPEN;
  int unsigned sink_left = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;

  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (!hold_done && items_taken >= HOLD_AT) begin
      hold_done  <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      if (sink_left == 0) begin
        sink_mode <= sink_mode_t'($urandom_range(0, 2));
        sink_left <= $urandom_range(8, 80);
      end else begin
        sink_left <= sink_left - 1;
      end
      case (sink_mode)
        SINK_OPEN: out_tready <= 1'b1;
        SINK_COIN: out_tready <= 1'($urandom_range(0, 1));
        default:   out_tready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  always @(posedge clk) begin : result_check
    map_result_t got, want;
    if (rst_n && out_tvalid === 1'b1 && out_tready === 1'b1) begin
      got = out_tdata[16:0];
      if (mapping_results_due.size() == 0) begin
        $display("%0t ns: result word with nothing expected, got %h", $time, out_tdata);
        mismatches++;
      end else begin
        want = mapping_results_due.pop_front();
        check_field("status", want.status, got.status);
        check_field("tables_added", want.added, got.added);
        check_field("leaf_table", want.leaf, got.leaf);
        check_field("free_tables_left", want.free_left, got.free_left);
        check_field("zero fill", 0, out_tdata[23:17]);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid === 1'b1 && in_tready === 1'b1) ||
        (out_tvalid === 1'b1 && out_tready === 1'b1))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("%0t ns: no word moved for %0d cycles", $time, IDLE_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    dir_row_t           dir_rows [DIR_N];
    logic [26:0]        prefix_pool [POOL_N];
    logic [TBL_W-1:0]   root_pick;
    logic [CNT_W-1:0]   free_pick;
    logic [FRAME_W-1:0] base_pick;
    logic [VPAGE_W-1:0] vp;
    logic [FRAME_W-1:0] fr;

    foreach (page_store[i]) page_store[i] = '0;
    root_q      = '0;
    next_free_q = 7'd1;
    base_q      = '0;

    dir_rows = '{
      known_row(36'h0, 40'h0, pmi_pkg::STATUS_MAPPED, 3, 3, 60),
      known_row(36'h0, FRAME_MAX, pmi_pkg::STATUS_MAPPED, 0, 3, 60),
      known_row(VPAGE_MAX, 40'h0, pmi_pkg::STATUS_MAPPED, 3, 6, 57),
      item_row(36'hA_AAAA_AAAA, 40'hAA_AAAA_AAAA),
      item_row(36'h5_5555_5555, 40'h55_5555_5555),
      item_row(36'h0_0000_01FF, 40'h12_3456_789A),
      cfg_row(pmi_pkg::CFG_ROOT_TABLE, 40'd3),
      known_row(36'h0, 40'h1, pmi_pkg::STATUS_OUTSIDE, 0, 0, 51),
      cfg_row(CFG_UNUSED, FRAME_MAX),
      item_row(36'h0_0800_0000, 40'h7),
      cfg_row(pmi_pkg::CFG_ROOT_TABLE, 40'd0),
      cfg_row(pmi_pkg::CFG_FIRST_FREE, 40'd62),
      known_row(36'h8_0000_0000, 40'h0, pmi_pkg::STATUS_NO_TABLE, 2, 0, 0),
      cfg_row(pmi_pkg::CFG_FIRST_FREE, 40'd64),
      known_row(36'h4_0000_0000, 40'h0, pmi_pkg::STATUS_NO_TABLE, 0, 0, 0),
      cfg_row(pmi_pkg::CFG_FIRST_FREE, 40'd127),
      known_row(36'h0, 40'hF0_0000_000F, pmi_pkg::STATUS_MAPPED, 0, 3, 0),
      cfg_row(pmi_pkg::CFG_FIRST_FREE, 40'd0),
      item_row(36'h2_0000_0000, 40'h0),
      cfg_row(pmi_pkg::CFG_TABLE_BASE, FRAME_MAX),
      item_row(36'h0, FRAME_MAX),
      item_row(VPAGE_MAX, 40'h0)
    };

    // Shared prefixes make later walks follow tables built by earlier ones.
    for (int i = 0; i < POOL_N; i++) begin
      if (i < 3) prefix_pool[i] = 27'($urandom());
      else if (i < 8) prefix_pool[i] = {prefix_pool[i % 3][26:9], 9'($urandom())};
      else prefix_pool[i] = {prefix_pool[i % 3][26:18], 18'($urandom())};
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        settle();
        set_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
      end else begin
        put_item(dir_rows[i].vp, dir_rows[i].fr, dir_rows[i].typed, dir_rows[i].res);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          root_pick = '0; free_pick = 7'd1; base_pick = '0;
        end
        1: begin
          root_pick = 6'd63; free_pick = 7'd64; base_pick = FRAME_MAX;
        end
        2: begin
          root_pick = '0; free_pick = 7'd0; base_pick = '0;
        end
        3: begin
          root_pick = 6'($urandom()); free_pick = 7'd127;
          base_pick = {8'($urandom()), $urandom()};
        end
        default: begin
          root_pick = 6'($urandom_range(0, 3));
          free_pick = 7'($urandom_range(1, TABLE_FRAMES - 1));
          base_pick = ($urandom_range(0, 3) == 0) ? {8'($urandom()), $urandom()} : base_q;
        end
      endcase
      settle();
      set_reg(pmi_pkg::CFG_TABLE_BASE, base_pick);
      set_reg(pmi_pkg::CFG_ROOT_TABLE, 40'(root_pick));
      set_reg(pmi_pkg::CFG_FIRST_FREE, 40'(free_pick));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 9) < 7)
          vp = {prefix_pool[$urandom_range(0, POOL_N - 1)], 9'($urandom())};
        else
          vp = {4'($urandom()), $urandom()};
        if ($urandom_range(0, 1) == 0)
          fr = base_q + 40'($urandom_range(0, TABLE_FRAMES - 1));
        else
          fr = {8'($urandom()), $urandom()};
        put_item(vp, fr, 1'b0, '0);
      end
    end

    settle();
    if (mismatches == 0 && mapping_results_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
